// ===== hdl/fnvlp_pkg.sv =====
// shared types and constants of the fnv1a linear-probe hash table
`default_nettype none
package fnvlp_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // result status codes
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // request operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // hashed request handed from front to back
  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] val;
    logic [31:0] hash;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  // one table slot as stored in memory
  typedef struct packed {
    logic        valid;
    logic [3:0]  len;
    logic [63:0] key;
    logic [63:0] val;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage
`default_nettype wire

// ===== hdl/fnvlp_front.sv =====
// front part: accepts requests, normalizes the key and computes the fnv-1a hash
`default_nettype none
module fnvlp_front #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hold,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [63:0]        key,
  input  wire logic [3:0]         len,
  input  wire logic [63:0]        val,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output fnvlp_pkg::req_t         push_req
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t         state;
  fnvlp_pkg::req_t req;
  logic [2:0]      bi;
  logic [3:0]      len_s;
  logic [63:0]     key_m;
  logic [7:0]      cur_byte;
  logic [31:0]     hash_next;

  // saturate length and clear bytes past it
  always_comb begin
    len_s = (len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : len;
    for (int b = 0; b < 8; b++) begin
      key_m[b*8 +: 8] = (4'(b) < len_s) ? key[b*8 +: 8] : 8'd0;
    end
  end

  // one hash round per cycle
  always_comb begin
    cur_byte  = req.key[{bi, 3'b000} +: 8];
    hash_next = (req.hash ^ {24'd0, cur_byte}) * fnvlp_pkg::FNV_PRIME;
  end

  assign in_ready   = (state == F_IDLE) && !hold;
  assign push_valid = (state == F_PUSH);
  assign push_req   = req;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      bi    <= 3'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            req.op   <= op;
            req.key  <= key_m;
            req.len  <= len_s;
            req.val  <= val;
            req.hash <= fnvlp_pkg::FNV_BASIS;
            bi       <= 3'd0;
            state    <= (len_s == 4'd0) ? F_PUSH : F_HASH;
          end
        end
        F_HASH: begin
          req.hash <= hash_next;
          bi       <= bi + 3'd1;
          if ({1'b0, bi} == req.len - 4'd1) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fnvlp_fifo.sv =====
// two-entry queue between the front and back parts
`default_nettype none
module fnvlp_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);

  logic [W-1:0] store [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;
  logic         do_wr;
  logic         do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = store[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wp] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) wp <= ~wp;
      if (do_rd) rp <= ~rp;
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fnvlp_back.sv =====
// back part: slot memory, clearing pass and linear probe sequencer
`default_nettype none
module fnvlp_back #(
  parameter int SLOTS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [10:0]  fill_limit,
  output logic              clearing,
  input  wire logic         req_valid,
  output logic              req_ready,
  input  wire fnvlp_pkg::req_t req_in,
  output logic              rsp_valid,
  input  wire logic         rsp_ready,
  output logic [1:0]        rsp_status,
  output logic [63:0]       rsp_value
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_SEND} bstate_t;

  bstate_t              state;
  fnvlp_pkg::req_t      cur;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     cnt;
  logic [IDX_W-1:0]     clr;
  logic [10:0]          entry_count;
  logic [fnvlp_pkg::SLOT_W-1:0] mem [SLOTS];
  fnvlp_pkg::slot_t     mem_q;
  logic [IDX_W-1:0]     raddr;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  fnvlp_pkg::slot_t     wdata;
  logic                 hit;
  logic                 empty;

  assign clearing  = (state == B_CLEAR);
  assign req_ready = (state == B_IDLE);
  assign rsp_valid = (state == B_SEND);
  assign hit   = mem_q.valid && (mem_q.len == cur.len) && (mem_q.key == cur.key);
  assign empty = !mem_q.valid;

  // read address and write port
  always_comb begin
    raddr = idx;
    we    = 1'b0;
    waddr = idx;
    wdata = mem_q;
    case (state)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
      end
      B_IDLE: raddr = req_in.hash[IDX_W-1:0];
      B_PROBE: begin
        raddr = idx + IDX_W'(1);
        if (cur.op == fnvlp_pkg::OP_PUT) begin
          if (empty && (entry_count < fill_limit)) begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.len   = cur.len;
            wdata.key   = cur.key;
            wdata.val   = cur.val;
          end else if (hit) begin
            we        = 1'b1;
            wdata.val = cur.val;
          end
        end
      end
      default: raddr = idx;
    endcase
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  // probe sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_CLEAR;
      clr         <= '0;
      entry_count <= 11'd0;
    end else begin
      case (state)
        B_CLEAR: begin
          clr <= clr + IDX_W'(1);
          if (clr == LAST) state <= B_IDLE;
        end
        B_IDLE: begin
          if (req_valid) begin
            cur   <= req_in;
            idx   <= req_in.hash[IDX_W-1:0];
            cnt   <= '0;
            state <= B_PROBE;
          end
        end
        B_PROBE: begin
          rsp_value <= (hit && (cur.op == fnvlp_pkg::OP_GET)) ? mem_q.val : 64'd0;
          if (empty) begin
            state <= B_SEND;
            if (cur.op == fnvlp_pkg::OP_GET) begin
              rsp_status <= fnvlp_pkg::ST_MISS;
            end else if (entry_count < fill_limit) begin
              rsp_status  <= fnvlp_pkg::ST_INSERTED;
              entry_count <= entry_count + 11'd1;
            end else begin
              rsp_status <= fnvlp_pkg::ST_FULL;
            end
          end else if (hit) begin
            state      <= B_SEND;
            rsp_status <= fnvlp_pkg::ST_FOUND;
          end else if (cnt == LAST) begin
            state      <= B_SEND;
            rsp_status <= (cur.op == fnvlp_pkg::OP_GET) ? fnvlp_pkg::ST_MISS
                                                         : fnvlp_pkg::ST_FULL;
          end else begin
            idx <= idx + IDX_W'(1);
            cnt <= cnt + IDX_W'(1);
          end
        end
        B_SEND: begin
          if (rsp_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // only a get hit carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != fnvlp_pkg::ST_FOUND) |-> rsp_value == 64'd0)
    else $error("nonzero value on a result other than found");

  // entry count grows by at most one per request and only on insert
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (entry_count != $past(entry_count)) |->
      (entry_count == $past(entry_count) + 11'd1) &&
      rsp_valid && (rsp_status == fnvlp_pkg::ST_INSERTED))
    else $error("entry count changed without insert");

  // no request taken while the memory is being cleared
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req_ready)
    else $error("request taken during clearing pass");

endmodule
`default_nettype wire

// ===== hdl/fnv1a_linear_probe_hash_table_core.sv =====
// top level of the fnv1a linear-probe hash table with apb register port
//
//  channel   dir  handshake              contents
//  s_axis    in   tvalid/tready          tuser: operation; tdata: key, length, value
//  m_axis    out  tvalid/tready          tuser: status; tdata: value_out
//  apb       in   psel/penable/pready    fill_limit at byte address 0
//
// the front captures a request, hashes it (one hash round per byte) and pushes it
// the back issues one slot memory read per probe
// after reset the back clears all SLOTS slots, one per cycle; s_axis_tready stays low
// a two-entry queue and the output register let both sides stall independently
`default_nettype none
module fnv1a_linear_probe_hash_table_core #(
  parameter int SLOTS         = 1024,
  parameter int MAX_KEY_BYTES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,  // key[63:0], key_length[67:64], value_in[131:68]
  input  wire logic         s_axis_tuser,  // operation
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // value_out[63:0]
  output logic [1:0]        m_axis_tuser,  // status[1:0]
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [10:0]     fill_limit;
  logic            clearing;
  logic            push_valid;
  logic            push_ready;
  fnvlp_pkg::req_t push_req;
  logic            q_valid;
  logic            q_ready;
  logic [fnvlp_pkg::REQ_W-1:0] q_data;
  logic            rsp_valid;
  logic            rsp_ready;
  logic [1:0]      rsp_status;
  logic [63:0]     rsp_value;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, fill_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_limit <= 11'd768;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      fill_limit <= pwdata[10:0];
    end
  end

  fnvlp_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .hold       (clearing),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .op         (s_axis_tuser),
    .key        (s_axis_tdata[63:0]),
    .len        (s_axis_tdata[67:64]),
    .val        (s_axis_tdata[131:68]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  fnvlp_fifo #(.W(fnvlp_pkg::REQ_W)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_req),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  fnvlp_back #(.SLOTS(SLOTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .fill_limit (fill_limit),
    .clearing   (clearing),
    .req_valid  (q_valid),
    .req_ready  (q_ready),
    .req_in     (fnvlp_pkg::req_t'(q_data)),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_status (rsp_status),
    .rsp_value  (rsp_value)
  );

  // output register
  assign rsp_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rsp_ready) begin
      m_axis_tvalid <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) begin
      m_axis_tdata <= rsp_value;
      m_axis_tuser <= rsp_status;
    end
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking bench for the fnv1a linear-probe hash table core
`timescale 1ns / 1ps
module testbench;

  localparam int NSLOT = 1024;
  localparam int NRAND = 1800;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    logic        op;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] val;
    logic        chk;
    logic [1:0]  st;
    logic [63:0] vout;
  } row_t;

  typedef struct {
    logic [1:0]  st;
    logic [63:0] vout;
  } answer_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // predictor copy of the table
  logic        tbl_valid [NSLOT];
  logic [63:0] tbl_key   [NSLOT];
  logic [3:0]  tbl_len   [NSLOT];
  logic [63:0] tbl_val   [NSLOT];
  int unsigned tbl_count;
  int unsigned tbl_limit;

  answer_t     pending_answers[$];
  row_t        directed_rows[$];
  logic [63:0] used_keys[$];
  logic [3:0]  used_lens[$];
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  fnv1a_linear_probe_hash_table_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bound on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [9:0] home_slot(logic [63:0] key, logic [3:0] len);
    logic [31:0] h;
    h = fnvlp_pkg::FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      h = (h ^ {24'd0, key[8*i +: 8]}) * fnvlp_pkg::FNV_PRIME;
    end
    return h[9:0];
  endfunction

  // work out the answer to one request and update the table copy
  function automatic answer_t lookup_or_store(logic op, logic [63:0] key_raw,
                                              logic [3:0] len_raw, logic [63:0] val);
    answer_t     a;
    logic [3:0]  len;
    logic [63:0] key;
    logic [9:0]  idx;
    logic        hit;
    logic        have_empty;
    len = (len_raw > 4'd8) ? 4'd8 : len_raw;
    key = (len >= 4'd8) ? key_raw : key_raw & ((64'd1 << (8 * len)) - 64'd1);
    idx = home_slot(key, len);
    hit = 1'b0;
    have_empty = 1'b0;
    for (int n = 0; n < NSLOT; n++) begin
      if (!tbl_valid[idx]) begin
        have_empty = 1'b1;
        break;
      end
      if (tbl_len[idx] == len && tbl_key[idx] == key) begin
        hit = 1'b1;
        break;
      end
      idx = idx + 10'd1;
    end
    a.vout = '0;
    if (op == fnvlp_pkg::OP_GET) begin
      a.st = hit ? fnvlp_pkg::ST_FOUND : fnvlp_pkg::ST_MISS;
      if (hit) a.vout = tbl_val[idx];
    end else if (hit) begin
      a.st = fnvlp_pkg::ST_FOUND;
      tbl_val[idx] = val;
    end else if (have_empty && tbl_count < tbl_limit) begin
      tbl_valid[idx] = 1'b1;
      tbl_key[idx] = key;
      tbl_len[idx] = len;
      tbl_val[idx] = val;
      tbl_count = (tbl_count + 1) & 11'h7ff;
      a.st = fnvlp_pkg::ST_INSERTED;
    end else begin
      a.st = fnvlp_pkg::ST_FULL;
    end
    return a;
  endfunction

  // result side: random stall and compare against oldest answer
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result status=%0d value=%h", m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          answer_t e;
          e = pending_answers.pop_front();
          if (m_axis_tuser !== e.st) begin
            $error("status expected %0d actual %0d", e.st, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata !== e.vout) begin
            $error("value_out expected %h actual %h", e.vout, m_axis_tdata);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_fill_limit(int unsigned value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= value; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tbl_limit = value & 11'h7ff;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // offer one request, hold valid until accepted
  task automatic send_request(logic op, logic [63:0] key, logic [3:0] len,
                              logic [63:0] val, logic chk, logic [1:0] st,
                              logic [63:0] vout);
    answer_t a;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'd0, val, len, key};
    do @(posedge clk); while (!s_axis_tready);
    a = lookup_or_store(op, key, len, val);
    if (chk && (a.st !== st || a.vout !== vout)) begin
      $error("predictor disagrees with table row: status %0d value %h", a.st, a.vout);
      errors++;
    end
    pending_answers.push_back(a);
  endtask

  function automatic row_t mk(logic op, logic [63:0] key, logic [3:0] len, logic [63:0] val,
                              logic chk = 1'b0, logic [1:0] st = fnvlp_pkg::ST_FOUND,
                              logic [63:0] vout = '0);
    row_t r;
    r.op = op; r.key = key; r.len = len; r.val = val;
    r.chk = chk; r.st = st; r.vout = vout;
    return r;
  endfunction

  task automatic random_phase(int count);
    logic [63:0] k;
    logic [3:0]  l;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 55 && used_keys.size() > 0) begin
        // revisit a known key
        int j;
        j = $urandom_range(used_keys.size() - 1);
        k = used_keys[j];
        l = used_lens[j];
        if ($urandom_range(9) == 0) k = k ^ {$urandom, $urandom};
      end else begin
        k = {$urandom, $urandom};
        l = (pick < 95) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
        if (pick < 75) l = 4'($urandom_range(2, 1));
        used_keys.push_back(k);
        used_lens.push_back(l);
      end
      send_request(logic'($urandom_range(1)), k, l, {$urandom, $urandom}, 1'b0,
                   fnvlp_pkg::ST_FOUND, 64'h0);
    end
  endtask

  initial begin
    tbl_count = 0;
    tbl_limit = 768;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_len[i] = '0;
      tbl_val[i] = '0;
    end
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = fnvlp_pkg::OP_GET;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 6;
    recv_idle_pct = 79;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table: extremes, both operations, length corner cases
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'h0, 4'd1, 64'h0,
                               1'b1, fnvlp_pkg::ST_MISS, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'hffff_ffff_ffff_ffff, 4'd8,
                               64'hffff_ffff_ffff_ffff, 1'b1, fnvlp_pkg::ST_INSERTED, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'hffff_ffff_ffff_ffff, 4'd8, 64'h1234,
                               1'b1, fnvlp_pkg::ST_FOUND, 64'hffff_ffff_ffff_ffff));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'hffff_ffff_ffff_ffff, 4'd8, 64'h0,
                               1'b1, fnvlp_pkg::ST_FOUND, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'hffff_ffff_ffff_ffff, 4'd15, 64'h0,
                               1'b1, fnvlp_pkg::ST_FOUND, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'h0, 4'd0, 64'h5555_aaaa_5555_aaaa,
                               1'b1, fnvlp_pkg::ST_INSERTED, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'hdead_beef_0000_0000, 4'd0, 64'h0,
                               1'b1, fnvlp_pkg::ST_FOUND, 64'h5555_aaaa_5555_aaaa));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'hffff_ffff_ffff_ff41, 4'd1, 64'h1,
                               1'b1, fnvlp_pkg::ST_INSERTED, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'h0000_0000_0000_0041, 4'd1, 64'h0,
                               1'b1, fnvlp_pkg::ST_FOUND, 64'h1));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'h0000_0000_0000_0041, 4'd2, 64'h0,
                               1'b1, fnvlp_pkg::ST_MISS, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'h0000_0000_0000_0041, 4'd2, 64'h2,
                               1'b1, fnvlp_pkg::ST_INSERTED, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'h0000_0000_0000_0041, 4'd2, 64'h0,
                               1'b1, fnvlp_pkg::ST_FOUND, 64'h2));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'h0123_4567_89ab_cdef, 4'd7,
                               64'hfedc_ba98_7654_3210));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'hff23_4567_89ab_cdef, 4'd7, 64'h0));
    directed_rows.push_back(mk(fnvlp_pkg::OP_PUT, 64'haaaa_aaaa_5555_5555, 4'd4,
                               64'h8000_0000_0000_0001));
    directed_rows.push_back(mk(fnvlp_pkg::OP_GET, 64'h0000_0000_5555_5555, 4'd4, 64'h0));
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].len,
                   directed_rows[i].val, directed_rows[i].chk, directed_rows[i].st,
                   directed_rows[i].vout);
    end

    // sender holds off until the table has answered everything
    wait_drained();
    // tight limit: inserts refused once reached, updates still allowed
    write_fill_limit(tbl_count + 3);
    random_phase(120);
    wait_drained();
    write_fill_limit(1);
    send_request(fnvlp_pkg::OP_PUT, 64'h77, 4'd3, 64'h9, 1'b1, fnvlp_pkg::ST_FULL, 64'h0);
    send_request(fnvlp_pkg::OP_PUT, 64'hffff_ffff_ffff_ffff, 4'd8, 64'h7, 1'b1,
                 fnvlp_pkg::ST_FOUND, 64'h0);
    wait_drained();
    write_fill_limit(1024);
    random_phase(NRAND / 3 - 120);
    send_idle_pct = 79;
    recv_idle_pct = 6;
    random_phase(NRAND / 3);
    wait_drained();
    write_fill_limit(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(NRAND / 3);
    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fnvlp_pkg.sv
hdl/fnvlp_front.sv
hdl/fnvlp_fifo.sv
hdl/fnvlp_back.sv
hdl/fnv1a_linear_probe_hash_table_core.sv
bench/testbench.sv
